>>> rtl/vzd_pkg.sv
// Package for the varint zigzag decoder: field widths, group constants, state type.
// No dependencies.
`default_nettype none

package vzd_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int NARROW_W = 32;
    localparam int COUNT_W  = 4;
    localparam int SHIFT_W  = 6;

    localparam int GROUP_BITS = 7;

    localparam logic [COUNT_W-1:0] LAST_GROUP = 4'd8;
    localparam logic [BYTE_W-1:0]  CONT_MASK  = 8'h80;
    localparam logic [BYTE_W-1:0]  DATA_MASK  = 8'h7f;

    typedef struct packed {
        logic [VALUE_W-1:0] accumulator;
        logic [COUNT_W-1:0] group_index;
        logic               latched_wide;
        logic               latched_signed;
    } dec_state_t;

endpackage

`default_nettype wire

>>> rtl/varint_zigzag_decoder_unit.sv
// Top level of the varint zigzag decoder: byte accumulation, zigzag, result register.
// Depends on vzd_pkg.
`default_nettype none

// Decodes little-endian base-128 varints, one byte per transaction, at one byte per
// clock. Each byte is folded into the running value in the cycle it is accepted; the
// final byte of a value (top bit clear, or the ninth byte) loads the result register,
// which presents value_bits and byte_count on the output channel.
// The width and signed flags count only on the first byte of a value. The input is
// stalled only while a finished result waits in the result register and out_ready is
// low; otherwise a byte is taken every cycle.
module varint_zigzag_decoder_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [vzd_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic                         wide,
    input  wire logic                         signed_value,

    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [vzd_pkg::VALUE_W-1:0]       value_bits,
    output logic [vzd_pkg::COUNT_W-1:0]       byte_count
);

    vzd_pkg::dec_state_t                state_reg;
    vzd_pkg::dec_state_t                state_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [vzd_pkg::VALUE_W-1:0]        value_bits_reg;
    logic [vzd_pkg::VALUE_W-1:0]        value_bits_next;
    logic [vzd_pkg::COUNT_W-1:0]        byte_count_reg;
    logic [vzd_pkg::COUNT_W-1:0]        byte_count_next;

    logic                               in_fire;
    logic                               out_fire;
    logic [vzd_pkg::COUNT_W-1:0]        idx;
    logic                               is_first;
    logic                               is_last_group;
    logic                               cur_wide;
    logic                               cur_signed;
    logic [vzd_pkg::BYTE_W-1:0]         payload;
    logic [vzd_pkg::SHIFT_W-1:0]        shift_amt;
    logic [vzd_pkg::VALUE_W-1:0]        acc_sum;
    logic [vzd_pkg::VALUE_W-1:0]        acc_masked;
    logic [vzd_pkg::VALUE_W-1:0]        zz;
    logic                               done;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        idx = (state_reg.group_index > vzd_pkg::LAST_GROUP) ? vzd_pkg::LAST_GROUP
                                                             : state_reg.group_index;
        is_first      = (idx == '0);
        is_last_group = (idx == vzd_pkg::LAST_GROUP);
        cur_wide      = is_first ? wide : state_reg.latched_wide;
        cur_signed    = is_first ? signed_value : state_reg.latched_signed;
        payload       = is_last_group ? byte_in : (byte_in & vzd_pkg::DATA_MASK);
        done          = is_last_group || ((byte_in & vzd_pkg::CONT_MASK) == '0);
        shift_amt     = vzd_pkg::SHIFT_W'(int'(idx) * vzd_pkg::GROUP_BITS);
        acc_sum       = state_reg.accumulator
                      | ({{(vzd_pkg::VALUE_W-vzd_pkg::BYTE_W){1'b0}}, payload} << shift_amt);
        acc_masked    = cur_wide ? acc_sum
                      : {{(vzd_pkg::VALUE_W-vzd_pkg::NARROW_W){1'b0}},
                         acc_sum[vzd_pkg::NARROW_W-1:0]};
        // zigzag: (v >> 1) ^ -(v & 1)
        zz = (acc_masked >> 1) ^ {vzd_pkg::VALUE_W{acc_masked[0]}};
        if (!cur_wide)
        begin
            zz[vzd_pkg::VALUE_W-1:vzd_pkg::NARROW_W] = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_fire;
        value_bits_next = value_bits_reg;
        byte_count_next = byte_count_reg;
        if (in_fire)
        begin
            if (done)
            begin
                state_next      = '0;
                out_valid_next  = 1'b1;
                value_bits_next = cur_signed ? zz : acc_masked;
                byte_count_next = idx + 4'd1;
            end
            else
            begin
                state_next.accumulator    = acc_masked;
                state_next.group_index    = idx + 4'd1;
                state_next.latched_wide   = cur_wide;
                state_next.latched_signed = cur_signed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_bits_reg <= value_bits_next;
        byte_count_reg <= byte_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign value_bits = value_bits_reg;
    assign byte_count = byte_count_reg;

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.group_index <= vzd_pkg::LAST_GROUP)
        else $error("group index past last group");

    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && done) |=> (out_valid && state_reg.group_index == '0))
        else $error("finished value did not load result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count >= 4'd1 && byte_count <= 4'd9))
        else $error("byte count out of range");

    a_narrow_acc: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.latched_wide
        |-> (state_reg.accumulator[vzd_pkg::VALUE_W-1:vzd_pkg::NARROW_W] == '0))
        else $error("narrow accumulator has high bits");
`endif

endmodule

`default_nettype wire

>>> tb/vzd_checker.sv
// Checker for the varint zigzag decoder: watches both channels, predicts decoded values.
// Depends on vzd_pkg; instantiated beside the block by tb.
`timescale 1ns / 100ps

module vzd_checker
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic [vzd_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                       wide,
    input  wire logic                       signed_value,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [vzd_pkg::VALUE_W-1:0] value_bits,
    input  wire logic [vzd_pkg::COUNT_W-1:0] byte_count,
    input  wire logic                       end_of_test,
    output int                              errors,
    output int                              pending,
    output int                              values_checked
);

    typedef struct packed {
        logic [vzd_pkg::VALUE_W-1:0] value;
        logic [vzd_pkg::COUNT_W-1:0] count;
    } decoded_t;

    decoded_t                    decoded_q[$];
    logic [vzd_pkg::VALUE_W-1:0] acc;
    logic [vzd_pkg::COUNT_W-1:0] grp;
    logic                        lat_wide;
    logic                        lat_signed;
    bit                          leftovers_done;

    initial begin
        errors = 0;
        pending = 0;
        values_checked = 0;
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // fold one byte into the running value; queue the decoded value when it ends
    task automatic fold_byte(input logic [vzd_pkg::BYTE_W-1:0] b, input logic w,
                             input logic s);
        logic [vzd_pkg::COUNT_W-1:0] pos;
        logic                        last;
        logic [vzd_pkg::VALUE_W-1:0] v;
        decoded_t                    item;
        pos = (grp > vzd_pkg::LAST_GROUP) ? vzd_pkg::LAST_GROUP : grp;
        if (pos == 0)
        begin
            lat_wide = w;
            lat_signed = s;
        end
        if (pos == vzd_pkg::LAST_GROUP)
        begin
            acc |= {b, 56'd0};
            last = 1'b1;
        end
        else
        begin
            acc |= vzd_pkg::VALUE_W'(b & vzd_pkg::DATA_MASK) << (vzd_pkg::GROUP_BITS * pos);
            last = (b & vzd_pkg::CONT_MASK) == 0;
        end
        if (!lat_wide)
            acc[vzd_pkg::VALUE_W-1:vzd_pkg::NARROW_W] = '0;
        if (!last)
            grp = pos + 1'b1;
        else
        begin
            v = acc;
            if (lat_signed)
            begin
                v = (v >> 1) ^ {vzd_pkg::VALUE_W{v[0]}};
                if (!lat_wide)
                    v[vzd_pkg::VALUE_W-1:vzd_pkg::NARROW_W] = '0;
            end
            item.value = v;
            item.count = pos + 1'b1;
            decoded_q.insert(decoded_q.size(), item);
            acc = '0;
            grp = '0;
            lat_wide = 1'b0;
            lat_signed = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t exp_val;
        if (!rst_n)
        begin
            acc = '0;
            grp = '0;
            lat_wide = 1'b0;
            lat_signed = 1'b0;
            decoded_q.delete();
            leftovers_done = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                fold_byte(byte_in, wide, signed_value);
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                    report($sformatf("unexpected value %h count %0d", value_bits, byte_count));
                else
                begin
                    exp_val = decoded_q.pop_front();
                    values_checked++;
                    if (value_bits !== exp_val.value)
                        report($sformatf("value_bits %h, expected %h",
                                         value_bits, exp_val.value));
                    if (byte_count !== exp_val.count)
                        report($sformatf("byte_count %0d, expected %0d",
                                         byte_count, exp_val.count));
                end
            end
            if (end_of_test && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                foreach (decoded_q[i])
                    report($sformatf("value %h count %0d never delivered",
                                     decoded_q[i].value, decoded_q[i].count));
            end
        end
        pending = decoded_q.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top for varint_zigzag_decoder_unit: clock, reset, byte stimulus, verdict.
// Depends on vzd_pkg, the decoder RTL and vzd_checker.
`timescale 1ns / 100ps

module tb;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [vzd_pkg::BYTE_W-1:0]    byte_in = '0;
    logic                          wide = 1'b0;
    logic                          signed_value = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [vzd_pkg::VALUE_W-1:0]   value_bits;
    logic [vzd_pkg::COUNT_W-1:0]   byte_count;
    logic                          end_of_test = 1'b0;
    int                            errors;
    int                            pending;
    int                            values_checked;

    bit                            quiet = 1'b0;
    bit                            hold_req = 1'b0;
    int                            bytes_fed = 0;

    always #10 clk = ~clk;

    varint_zigzag_decoder_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .wide         (wide),
        .signed_value (signed_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value_bits   (value_bits),
        .byte_count   (byte_count)
    );

    vzd_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .wide           (wide),
        .signed_value   (signed_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value_bits     (value_bits),
        .byte_count     (byte_count),
        .end_of_test    (end_of_test),
        .errors         (errors),
        .pending        (pending),
        .values_checked (values_checked)
    );

    initial
    begin
        #4_000_000;
        $display("Timeout with %0d values outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall bursts, one long hold on request, none at the end
    initial
    begin
        bit held;
        int n;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (quiet)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n - 1) @(posedge clk);
            end
        end
    end

    // one transaction on the byte channel, with an occasional idle burst before it
    task automatic feed_byte(input logic [vzd_pkg::BYTE_W-1:0] b, input logic w,
                             input logic s);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= b;
        wide <= w;
        signed_value <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_fed++;
    endtask

    // later bytes carry the opposite flags, which must be ignored
    task automatic feed_seq(input logic [vzd_pkg::BYTE_W-1:0] seq[$], input logic w,
                            input logic s);
        foreach (seq[i])
            feed_byte(seq[i], (i == 0) ? w : ~w, (i == 0) ? s : ~s);
    endtask

    // well-formed value of len bytes with random payload and random later flags
    task automatic feed_value(input int len, input logic w, input logic s);
        logic [vzd_pkg::BYTE_W-1:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = vzd_pkg::BYTE_W'($urandom_range(0, 255));
            if (i < len - 1)
                b[7] = 1'b1;
            else if (len < 9)
                b[7] = 1'b0;
            if (i == 0)
                feed_byte(b, w, s);
            else
                feed_byte(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int len;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        feed_seq('{8'h00}, 1'b0, 1'b0);
        feed_seq('{8'h7f}, 1'b1, 1'b1);
        feed_seq('{8'h01}, 1'b0, 1'b1);
        // narrow overflow on the fifth byte
        feed_seq('{8'hff, 8'hff, 8'hff, 8'hff, 8'h7f}, 1'b0, 1'b1);
        // ninth byte taken whole
        feed_seq('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff},
                 1'b1, 1'b1);
        // nine bytes in narrow mode: upper groups all dropped
        feed_seq('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff},
                 1'b0, 1'b0);

        while (bytes_fed < 730)
        begin
            if (bytes_fed >= 320 && !hold_req)
                hold_req = 1'b1;
            if (bytes_fed >= 660)
                quiet = 1'b1;
            if ($urandom_range(0, 4) != 0)
            begin
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 9);
                feed_value(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    feed_byte(vzd_pkg::BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        // close any value left open by noise
        feed_byte(8'h00, 1'b0, 1'b0);
        in_valid <= 1'b0;

        n = 0;
        @(negedge clk);
        while (pending != 0 && n < 2000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Fed %0d bytes, checked %0d decoded values", bytes_fed, values_checked);
        $display("Covered narrow/wide, zigzag on/off, 1 to 9 byte values, output back-pressure");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
